// ----- rtl/sse_pkg.sv -----
// Shared types and codes for the substring search engine.
package sse_pkg;

	// Item modes
	typedef enum logic [1:0] {
		MODE_HAY_APPEND    = 2'd0,
		MODE_NEEDLE_APPEND = 2'd1,
		MODE_QUERY         = 2'd2,
		MODE_CLEAR         = 2'd3
	} mode_t;

	// Query kinds; codes 5 to 7 carry no meaning
	typedef enum logic [2:0] {
		QK_LEFTMOST  = 3'd0,
		QK_RIGHTMOST = 3'd1,
		QK_COUNT     = 3'd2,
		QK_PREFIX    = 3'd3,
		QK_SUFFIX    = 3'd4
	} query_kind_t;

	// Value reported for a leftmost or rightmost miss and for the unused query kinds
	localparam logic [7:0] MISS_VALUE = 8'hFF;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  data_byte;
		query_kind_t query_kind;
	} cmd_word_t;

	typedef struct packed {
		logic signed [7:0] result_value;
		logic              match_flag;
		logic              overflow_flag;
	} res_word_t;

	// Scan sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COMPARE,
		ST_DONE
	} scan_state_t;

endpackage

// ----- rtl/sse_chan_if.sv -----
// Valid/ready channel carrying one word of a given type.
interface sse_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sse_byte_ram.sv -----
// Byte-wide synchronous RAM, one write port and one registered read port.
module sse_byte_ram #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/substring_search_engine.sv -----
// Substring search engine top level: byte stores, scan sequencer and result register.
//
//  channel | dir | word       | contents
//  cmd     | in  | cmd_word_t | mode, data_byte, query_kind
//  res     | out | res_word_t | result_value, match_flag, overflow_flag (queries only)
//
// Appends and clears are taken in the idle state. A query starts from idle, then for
// each haystack position tried reads and compares each needle byte in turn (a RAM
// read in CHECK, a compare in COMPARE), plus a closing check when the whole needle
// matched there, then hands the word to the result register in DONE. The pace is set
// by the single read port of each byte RAM. Reset clears lengths, overflow and control;
// the RAMs need no clearing. cmd stalls during a query scan and while its word waits
// for the result register; res holding a word does not stall appends.
module substring_search_engine
	import sse_pkg::*;
#(
	parameter int unsigned STRING_CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	sse_chan_if.sink       cmd,
	sse_chan_if.source     res
);

	localparam int unsigned LW = $clog2(STRING_CAPACITY + 1);
	localparam int unsigned AW = (STRING_CAPACITY > 1) ? $clog2(STRING_CAPACITY) : 1;

	scan_state_t state_q, state_d;

	logic [LW-1:0] hlen_q, nlen_q;
	logic          ovf_q;
	query_kind_t   kind_q, kind_d;
	logic [LW:0]   pos_q, pos_d;
	logic [LW-1:0] k_q, k_d;
	logic [LW:0]   best_q, best_d;
	logic          found_q, found_d;
	logic [LW-1:0] seen_q, seen_d;
	logic [7:0]    val_q, val_d;
	logic          flag_q, flag_d;
	logic          load_out;

	logic          res_valid_q;
	res_word_t     res_word_q;

	logic          cmd_acc;
	logic          hay_wr, ndl_wr;
	logic          rd_en;
	logic [AW-1:0] hay_rd_addr;
	logic [7:0]    hay_rd_data, ndl_rd_data;
	logic [LW:0]   last_w;
	logic          fits_w;
	logic [LW:0]   step_w;
	logic [LW:0]   pos_next_w;
	logic          finish;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);

	// last start position at which the needle still fits
	assign fits_w = (nlen_q <= hlen_q);
	assign last_w = {1'b0, hlen_q} - {1'b0, nlen_q};

	// byte RAMs
	assign hay_wr = cmd_acc && (cmd.data.mode == MODE_HAY_APPEND)
		&& (hlen_q < LW'(STRING_CAPACITY));
	assign ndl_wr = cmd_acc && (cmd.data.mode == MODE_NEEDLE_APPEND)
		&& (nlen_q < LW'(STRING_CAPACITY));

	assign rd_en       = (state_q == ST_CHECK) && (k_q != nlen_q);
	assign hay_rd_addr = AW'(pos_q + (LW + 1)'(k_q));

	sse_byte_ram #(.DEPTH(STRING_CAPACITY)) u_hay_ram (
		.clk     (clk),
		.wr_en   (hay_wr),
		.wr_addr (hlen_q[AW-1:0]),
		.wr_data (cmd.data.data_byte),
		.rd_en   (rd_en),
		.rd_addr (hay_rd_addr),
		.rd_data (hay_rd_data)
	);

	sse_byte_ram #(.DEPTH(STRING_CAPACITY)) u_ndl_ram (
		.clk     (clk),
		.wr_en   (ndl_wr),
		.wr_addr (nlen_q[AW-1:0]),
		.wr_data (cmd.data.data_byte),
		.rd_en   (rd_en),
		.rd_addr (k_q[AW-1:0]),
		.rd_data (ndl_rd_data)
	);

	// lengths and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlen_q <= '0;
			nlen_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd_acc) begin
			unique case (cmd.data.mode)
				MODE_HAY_APPEND: begin
					if (hay_wr) hlen_q <= hlen_q + LW'(1);
					else ovf_q <= 1'b1;
				end
				MODE_NEEDLE_APPEND: begin
					if (ndl_wr) nlen_q <= nlen_q + LW'(1);
					else ovf_q <= 1'b1;
				end
				MODE_CLEAR: begin
					hlen_q <= '0;
					nlen_q <= '0;
					ovf_q  <= 1'b0;
				end
				MODE_QUERY: ;
				default: ;
			endcase
		end
	end

	// next start position: a counted match skips the whole needle
	assign step_w = ((state_q == ST_CHECK) && (kind_q == QK_COUNT))
		? (LW + 1)'(nlen_q) : (LW + 1)'(1);
	assign pos_next_w = pos_q + step_w;

	// scan sequencer
	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		pos_d    = pos_q;
		k_d      = k_q;
		best_d   = best_q;
		found_d  = found_q;
		seen_d   = seen_q;
		val_d    = val_q;
		flag_d   = flag_q;
		load_out = 1'b0;
		finish   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && (cmd.data.mode == MODE_QUERY)) begin
					kind_d  = cmd.data.query_kind;
					pos_d   = (cmd.data.query_kind == QK_SUFFIX) ? last_w : '0;
					k_d     = '0;
					found_d = 1'b0;
					seen_d  = '0;
					val_d   = MISS_VALUE;
					flag_d  = 1'b0;
					state_d = ST_DONE;
					unique case (cmd.data.query_kind)
						QK_LEFTMOST, QK_RIGHTMOST: begin
							if (fits_w) state_d = ST_CHECK;
						end
						QK_COUNT: begin
							if (nlen_q == '0) begin
								val_d  = 8'(hlen_q) + 8'd1;
								flag_d = 1'b1;
							end else if (fits_w) begin
								state_d = ST_CHECK;
							end else begin
								val_d = 8'd0;
							end
						end
						QK_PREFIX, QK_SUFFIX: begin
							val_d = 8'd0;
							if (fits_w) state_d = ST_CHECK;
						end
						default: ;
					endcase
				end
			end

			ST_CHECK: begin
				if (k_q == nlen_q) begin
					// whole needle matched at pos_q
					unique case (kind_q)
						QK_LEFTMOST: begin
							val_d   = 8'(pos_q);
							flag_d  = 1'b1;
							state_d = ST_DONE;
						end
						QK_PREFIX, QK_SUFFIX: begin
							flag_d  = 1'b1;
							state_d = ST_DONE;
						end
						QK_RIGHTMOST: begin
							best_d  = pos_q;
							found_d = 1'b1;
							finish  = 1'b1;
						end
						QK_COUNT: begin
							seen_d = seen_q + LW'(1);
							finish = 1'b1;
						end
						default: state_d = ST_DONE;
					endcase
				end else begin
					state_d = ST_COMPARE;
				end
			end

			ST_COMPARE: begin
				if (hay_rd_data == ndl_rd_data) begin
					k_d     = k_q + LW'(1);
					state_d = ST_CHECK;
				end else if ((kind_q == QK_PREFIX) || (kind_q == QK_SUFFIX)) begin
					state_d = ST_DONE;
				end else begin
					finish = 1'b1;
				end
			end

			ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase

		// move to the next start position or close the scan
		if (finish) begin
			k_d = '0;
			if (pos_next_w <= last_w) begin
				pos_d   = pos_next_w;
				state_d = ST_CHECK;
			end else begin
				state_d = ST_DONE;
				if (kind_q == QK_RIGHTMOST) begin
					val_d  = found_d ? 8'(best_d) : MISS_VALUE;
					flag_d = found_d;
				end else if (kind_q == QK_COUNT) begin
					val_d  = 8'(seen_d);
					flag_d = (seen_d != '0);
				end else begin
					val_d  = MISS_VALUE;
					flag_d = 1'b0;
				end
			end
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		pos_q   <= pos_d;
		k_q     <= k_d;
		best_q  <= best_d;
		found_q <= found_d;
		seen_q  <= seen_d;
		val_q   <= val_d;
		flag_q  <= flag_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_word_q.result_value  <= $signed(val_q);
			res_word_q.match_flag    <= flag_q;
			res_word_q.overflow_flag <= ovf_q;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_word_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hlen_q <= LW'(STRING_CAPACITY)) && (nlen_q <= LW'(STRING_CAPACITY)))
		else $error("string length beyond capacity");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> $past(rd_en))
		else $error("compare without a RAM read in the cycle before");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CHECK) || (state_q == ST_COMPARE)) |-> (fits_w && (pos_q <= last_w)))
		else $error("scan position past last start");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!res_valid_q || res.ready))
		else $error("result word overwritten before taken");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the substring search engine: stimulus queue, driver, monitor, predictor.
module tb
	import sse_pkg::*;
();

	localparam int CAP      = 64;
	localparam int LONG_GAP = 60;
	localparam int TAIL     = 64;
	localparam int RANDOM_ITEMS = 1700;

	logic clk;
	logic arst_n = 1'b0;

	sse_chan_if #(.word_t(cmd_word_t)) cmd_ch ();
	sse_chan_if #(.word_t(res_word_t)) res_ch ();

	substring_search_engine #(.STRING_CAPACITY(CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Words waiting to be sent, and answers the engine still owes
	cmd_word_t cmd_backlog[$];
	res_word_t pending_answers[$];

	// Predictor copy of the engine's stores
	logic [7:0] hay_mem [CAP];
	logic [7:0] ndl_mem [CAP];
	int         hay_len  = 0;
	int         ndl_len  = 0;
	logic       ovf_seen = 1'b0;

	// Generation-time shadow of the stores, used to build needles and size the budget
	logic [7:0] gen_hay[$];
	logic [7:0] gen_ndl[$];
	logic [7:0] alpha [4];
	int         nsym = 1;
	longint     budget = 0;

	longint     cycles = 0;
	int         fault_count = 0;
	int         send_gap = 0;
	int         hold_gap = 0;
	bit         calm_spell = 1'b0;
	res_word_t  answer_due;
	res_word_t  answer_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Random gap length: mostly none, some short, a few long, with calm spells
	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 63) == 0)
			calm_spell = !calm_spell;
		if (calm_spell)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, LONG_GAP);
	endfunction

	function automatic logic [7:0] alpha_byte();
		return alpha[$urandom_range(0, nsym - 1)];
	endfunction

	function automatic query_kind_t rand_kind();
		if ($urandom_range(0, 19) == 0)
			return query_kind_t'($urandom_range(5, 7));
		return query_kind_t'($urandom_range(0, 4));
	endfunction

	// Queue one word and account for its worst-case cost in the run budget
	function automatic void push_cmd(input mode_t m, input logic [7:0] b, input query_kind_t k);
		cmd_word_t w;
		int        tries;
		w.mode       = m;
		w.data_byte  = b;
		w.query_kind = k;
		cmd_backlog.push_back(w);
		budget += 2 + LONG_GAP;
		case (m)
			MODE_HAY_APPEND: begin
				if (gen_hay.size() < CAP)
					gen_hay.push_back(b);
			end
			MODE_NEEDLE_APPEND: begin
				if (gen_ndl.size() < CAP)
					gen_ndl.push_back(b);
			end
			MODE_CLEAR: begin
				gen_hay.delete();
				gen_ndl.delete();
			end
			default: begin
				tries = gen_hay.size() - gen_ndl.size() + 1;
				if (tries < 1)
					tries = 1;
				budget += tries * (2 * gen_ndl.size() + 1) + 8 + LONG_GAP;
			end
		endcase
	endfunction

	// Needle fits at pos and equals the haystack there
	function automatic logic match_at(input int pos);
		int k;
		if (pos > hay_len || ndl_len > hay_len - pos)
			return 1'b0;
		for (k = 0; k < ndl_len; k++)
			if (hay_mem[pos + k] != ndl_mem[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Apply one accepted word to the predicted state; queries queue an answer
	function automatic void predict_search(input cmd_word_t w);
		res_word_t ans;
		int        value;
		logic      found;
		int        pos;
		int        seen;
		value = -1;
		found = 1'b0;
		case (w.mode)
			MODE_HAY_APPEND: begin
				if (hay_len < CAP) begin
					hay_mem[hay_len] = w.data_byte;
					hay_len++;
				end else
					ovf_seen = 1'b1;
			end
			MODE_NEEDLE_APPEND: begin
				if (ndl_len < CAP) begin
					ndl_mem[ndl_len] = w.data_byte;
					ndl_len++;
				end else
					ovf_seen = 1'b1;
			end
			MODE_CLEAR: begin
				hay_len  = 0;
				ndl_len  = 0;
				ovf_seen = 1'b0;
			end
			default: begin
				if (w.query_kind == QK_LEFTMOST || w.query_kind == QK_RIGHTMOST) begin
					if (ndl_len <= hay_len) begin
						for (pos = 0; pos <= hay_len - ndl_len; pos++) begin
							if (match_at(pos)) begin
								value = pos;
								found = 1'b1;
								if (w.query_kind == QK_LEFTMOST)
									break;
							end
						end
					end
				end else if (w.query_kind == QK_COUNT) begin
					if (ndl_len == 0)
						value = hay_len + 1;
					else begin
						seen = 0;
						pos  = 0;
						while (pos <= hay_len && ndl_len <= hay_len - pos) begin
							if (match_at(pos)) begin
								seen++;
								pos += ndl_len;
							end else
								pos++;
						end
						value = seen;
					end
					found = (value != 0);
				end else if (w.query_kind == QK_PREFIX || w.query_kind == QK_SUFFIX) begin
					value = 0;
					if (ndl_len <= hay_len)
						found = match_at(w.query_kind == QK_PREFIX ? 0 : hay_len - ndl_len);
				end
				ans.result_value  = value[7:0];
				ans.match_flag    = found;
				ans.overflow_flag = ovf_seen;
				pending_answers.push_back(ans);
			end
		endcase
	endfunction

	// Command driver: holds each word until taken, then an optional gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data  <= '0;
			send_gap     <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				predict_search(cmd_ch.data);
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					cmd_ch.valid <= 1'b0;
					send_gap     <= send_gap - 1;
				end else if (cmd_backlog.size() != 0) begin
					cmd_ch.data  <= cmd_backlog.pop_front();
					cmd_ch.valid <= 1'b1;
					send_gap     <= pick_gap();
				end else
					cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor: random back-pressure, compares each word with the oldest answer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_gap     <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				answer_seen = res_ch.data;
				if (pending_answers.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected result word: value %0d match %0b overflow %0b",
							answer_seen.result_value, answer_seen.match_flag,
							answer_seen.overflow_flag);
					fault_count++;
				end else begin
					answer_due = pending_answers.pop_front();
					if (answer_seen.result_value !== answer_due.result_value
							|| answer_seen.match_flag !== answer_due.match_flag
							|| answer_seen.overflow_flag !== answer_due.overflow_flag) begin
						if (fault_count < 10)
							$display("mismatch: value %0d/%0d match %0b/%0b overflow %0b/%0b (exp/got)",
								answer_due.result_value, answer_seen.result_value,
								answer_due.match_flag, answer_seen.match_flag,
								answer_due.overflow_flag, answer_seen.overflow_flag);
						fault_count++;
					end
				end
			end
			if (hold_gap > 0) begin
				res_ch.ready <= 1'b0;
				hold_gap     <= hold_gap - 1;
			end else begin
				res_ch.ready <= 1'b1;
				hold_gap     <= pick_gap();
			end
		end
	end

	initial begin
		int     r;
		int     hlen;
		int     nlen;
		int     start;
		int     i;
		int     stop_at;
		bit     fill_first;
		bit     timed_out;
		longint limit;

		// Directed: empty needle on an empty haystack, every defined kind
		push_cmd(MODE_QUERY, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_RIGHTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_COUNT);
		push_cmd(MODE_QUERY, 8'h00, QK_PREFIX);
		push_cmd(MODE_QUERY, 8'h00, QK_SUFFIX);
		// Extreme bytes in the haystack, empty needle rightmost and count
		push_cmd(MODE_HAY_APPEND, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_HAY_APPEND, 8'hFF, QK_LEFTMOST);
		push_cmd(MODE_HAY_APPEND, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'hFF, QK_RIGHTMOST);
		push_cmd(MODE_QUERY, 8'hFF, QK_COUNT);
		// Single-byte needle, and the kinds with no meaning
		push_cmd(MODE_NEEDLE_APPEND, 8'hFF, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, query_kind_t'(3'd5));
		push_cmd(MODE_QUERY, 8'h00, query_kind_t'(3'd7));
		// Needle longer than the haystack
		push_cmd(MODE_NEEDLE_APPEND, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_NEEDLE_APPEND, 8'hFF, QK_LEFTMOST);
		push_cmd(MODE_NEEDLE_APPEND, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_PREFIX);
		// Overlapping occurrences counted without overlap, then a miss
		push_cmd(MODE_CLEAR, 8'h00, QK_LEFTMOST);
		push_cmd(MODE_HAY_APPEND, 8'h41, QK_LEFTMOST);
		push_cmd(MODE_HAY_APPEND, 8'h41, QK_LEFTMOST);
		push_cmd(MODE_HAY_APPEND, 8'h41, QK_LEFTMOST);
		push_cmd(MODE_NEEDLE_APPEND, 8'h41, QK_LEFTMOST);
		push_cmd(MODE_NEEDLE_APPEND, 8'h41, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_COUNT);
		push_cmd(MODE_QUERY, 8'h00, QK_RIGHTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_SUFFIX);
		push_cmd(MODE_NEEDLE_APPEND, 8'h42, QK_LEFTMOST);
		push_cmd(MODE_QUERY, 8'h00, QK_PREFIX);
		push_cmd(MODE_QUERY, 8'h00, QK_LEFTMOST);

		// Random scenarios; the first one overfills both stores
		stop_at    = cmd_backlog.size() + RANDOM_ITEMS;
		fill_first = 1'b1;
		while (cmd_backlog.size() < stop_at) begin
			r = $urandom_range(0, 99);
			nsym = $urandom_range(1, 4);
			for (i = 0; i < 4; i++)
				alpha[i] = 8'($urandom);
			if (fill_first || r < 80) begin
				// Well-formed: clear (mostly), load haystack and needle, then a few queries
				if ($urandom_range(0, 9) != 0 || fill_first)
					push_cmd(MODE_CLEAR, 8'($urandom), query_kind_t'($urandom_range(0, 7)));
				r = $urandom_range(0, 99);
				if (fill_first)
					hlen = $urandom_range(65, 70);
				else if (r < 85)
					hlen = $urandom_range(0, 12);
				else if (r < 95)
					hlen = $urandom_range(13, 40);
				else
					hlen = $urandom_range(60, 70);
				repeat (hlen)
					push_cmd(MODE_HAY_APPEND, alpha_byte(), query_kind_t'($urandom_range(0, 7)));
				r = $urandom_range(0, 99);
				if (fill_first) begin
					repeat ($urandom_range(65, 68))
						push_cmd(MODE_NEEDLE_APPEND, alpha_byte(),
							query_kind_t'($urandom_range(0, 7)));
				end else if (r < 60 && gen_hay.size() > 0) begin
					// Needle cut from the haystack, often at its tail
					nlen = $urandom_range(0, gen_hay.size() < 6 ? gen_hay.size() : 6);
					if ($urandom_range(0, 2) == 0)
						start = gen_hay.size() - nlen;
					else
						start = $urandom_range(0, gen_hay.size() - nlen);
					for (i = 0; i < nlen; i++)
						push_cmd(MODE_NEEDLE_APPEND, gen_hay[start + i],
							query_kind_t'($urandom_range(0, 7)));
				end else begin
					if (r < 90)
						nlen = $urandom_range(0, 4);
					else if (r < 97)
						nlen = gen_hay.size() + $urandom_range(1, 3);
					else
						nlen = $urandom_range(62, 68);
					repeat (nlen)
						push_cmd(MODE_NEEDLE_APPEND, alpha_byte(),
							query_kind_t'($urandom_range(0, 7)));
				end
				repeat ($urandom_range(1, 5))
					push_cmd(MODE_QUERY, 8'($urandom), rand_kind());
				// Sometimes grow the haystack and ask again without clearing
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3))
						push_cmd(MODE_HAY_APPEND, alpha_byte(),
							query_kind_t'($urandom_range(0, 7)));
					push_cmd(MODE_QUERY, 8'($urandom), rand_kind());
				end
				fill_first = 1'b0;
			end else if (r < 95) begin
				// Noise: raw words of any mode
				repeat ($urandom_range(1, 8))
					push_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom),
						query_kind_t'($urandom_range(0, 7)));
			end else begin
				// Broken: clear in the middle of loading, then query
				repeat ($urandom_range(1, 4))
					push_cmd(MODE_HAY_APPEND, alpha_byte(), rand_kind());
				push_cmd(MODE_CLEAR, 8'($urandom), rand_kind());
				repeat ($urandom_range(0, 3))
					push_cmd(MODE_NEEDLE_APPEND, alpha_byte(), rand_kind());
				push_cmd(MODE_QUERY, 8'($urandom), rand_kind());
			end
		end

		limit = 3 * budget + 20000;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word sent and every answer returned, or for the time limit
		while (!(cmd_backlog.size() == 0 && !cmd_ch.valid && pending_answers.size() == 0)
				&& cycles < limit)
			@(posedge clk);
		timed_out = (cycles >= limit);
		repeat (TAIL) @(posedge clk);

		if (fault_count == 0 && !timed_out)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
